// ===== hdl/dstwr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstwr_pkg
// Shared types and constants for the double-sided two-way ranging
// time-of-flight block.
// ----------------------------------------------------------------------------
package dstwr_pkg;

   localparam int STAMP_BITS_DEF = 32;
   localparam int QUEUE_DEPTH    = 2;

   typedef struct packed {
      logic [31:0] init_poll_sent;
      logic [31:0] init_resp_recv;
      logic [31:0] init_final_sent;
      logic [31:0] resp_poll_recv;
      logic [31:0] resp_resp_sent;
      logic [31:0] resp_final_recv;
   } req_item_type;

   typedef struct packed {
      logic signed [32:0] flight_time;
      logic               zero_divisor;
   } rsp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hdl/dstwr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstwr_front
// Accepts an item, forms the four wrapped intervals and their sum, flags a
// zero sum and hands the job to the queue.
// ----------------------------------------------------------------------------
module dstwr_front #(
   parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  dstwr_pkg::req_item_type      req_data,
   input  dstwr_pkg::queue_status_type  q_status,
   output logic                         push,
   output logic [5*STAMP_BITS+2:0]      job
);
   import dstwr_pkg::*;

   localparam int DW = STAMP_BITS + 2;
   localparam int JW = 4*STAMP_BITS + DW + 1;

   logic [STAMP_BITS-1:0] ips, irr, ifs, rpr, rrs, rfr;
   logic [STAMP_BITS-1:0] ra, da, rb, db;
   logic [DW-1:0]         den;
   logic                  front_go;
   logic                  front_vld_ff, front_vld_in;
   logic [JW-1:0]         job_ff, job_in;

   always_comb begin
      ips = STAMP_BITS'(req_data.init_poll_sent);
      irr = STAMP_BITS'(req_data.init_resp_recv);
      ifs = STAMP_BITS'(req_data.init_final_sent);
      rpr = STAMP_BITS'(req_data.resp_poll_recv);
      rrs = STAMP_BITS'(req_data.resp_resp_sent);
      rfr = STAMP_BITS'(req_data.resp_final_recv);
      ra  = irr - ips;
      da  = ifs - irr;
      rb  = rfr - rrs;
      db  = rrs - rpr;
      den = DW'(ra) + DW'(rb) + DW'(da) + DW'(db);
   end

   always_comb begin
      front_go     = !front_vld_ff || !q_status.full;
      busy         = !front_go;
      push         = front_vld_ff && !q_status.full;
      front_vld_in = front_go ? start : front_vld_ff;
      job_in       = job_ff;
      if (start && front_go) begin
         job_in = {ra, rb, da, db, den, (den == '0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job = job_ff;

endmodule

// ===== hdl/dstwr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstwr_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module dstwr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = dstwr_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output dstwr_pkg::queue_status_type  status
);
   import dstwr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == CW'(DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];

endmodule

// ===== hdl/dstwr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstwr_back
// Split products, numerator difference, one-bit-per-stage restoring divider
// and saturation to the signed result, forced to zero on a zero divisor.
// ----------------------------------------------------------------------------
module dstwr_back #(
   parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dstwr_pkg::queue_status_type  q_status,
   output logic                         pop,
   input  logic [5*STAMP_BITS+2:0]      job,
   output logic                         rsp_valid,
   output dstwr_pkg::rsp_item_type      rsp_data
);
   import dstwr_pkg::*;

   localparam int S  = STAMP_BITS;
   localparam int DW = S + 2;
   localparam int H  = (S + 1) / 2;
   localparam int L  = S - H;
   localparam int QW = 2 * S;
   localparam int EW = (QW > 34) ? QW : 34;
   localparam logic [EW-1:0] POS_LIM = EW'(34'h0_FFFF_FFFF);
   localparam logic [EW-1:0] NEG_LIM = EW'(34'h1_0000_0000);

   logic [S-1:0]  ra, rb, da, db;
   logic [DW-1:0] job_den;
   logic          job_zero;

   // product stage
   logic            m1_vld_ff;
   logic [2*H-1:0]  m1_p_ll_ff, m1_q_ll_ff;
   logic [H+L-1:0]  m1_p_lh_ff, m1_p_hl_ff, m1_q_lh_ff, m1_q_hl_ff;
   logic [2*L-1:0]  m1_p_hh_ff, m1_q_hh_ff;
   logic [DW-1:0]   m1_den_ff;
   logic            m1_zero_ff;

   // sum stage
   logic            m2_vld_ff;
   logic [QW-1:0]   m2_p_ff, m2_q_ff, m2_p_in, m2_q_in;
   logic [DW-1:0]   m2_den_ff;
   logic            m2_zero_ff;

   // divider stages, index 0 holds the magnitude
   logic            div_vld_ff  [QW+1];
   logic [QW-1:0]   div_quo_ff  [QW+1];
   logic [DW-1:0]   div_rem_ff  [QW+1];
   logic [DW-1:0]   div_den_ff  [QW+1];
   logic            div_neg_ff  [QW+1];
   logic            div_zero_ff [QW+1];
   logic [QW-1:0]   div_quo_in  [QW+1];
   logic [DW-1:0]   div_rem_in  [QW+1];
   logic [QW-1:0]   mag_in;
   logic            neg_in;

   // output stage
   logic            out_vld_ff;
   rsp_item_type    out_data_ff, out_data_in;
   logic [EW-1:0]   quo_ext;
   logic [32:0]     mag33;

   assign pop = !q_status.empty;
   assign {ra, rb, da, db, job_den, job_zero} = job;

   always_ff @(posedge clock) begin
      m1_p_ll_ff <= (2*H)'(ra[H-1:0]) * (2*H)'(rb[H-1:0]);
      m1_p_lh_ff <= (H+L)'(ra[H-1:0]) * (H+L)'(rb[S-1:H]);
      m1_p_hl_ff <= (H+L)'(ra[S-1:H]) * (H+L)'(rb[H-1:0]);
      m1_p_hh_ff <= (2*L)'(ra[S-1:H]) * (2*L)'(rb[S-1:H]);
      m1_q_ll_ff <= (2*H)'(da[H-1:0]) * (2*H)'(db[H-1:0]);
      m1_q_lh_ff <= (H+L)'(da[H-1:0]) * (H+L)'(db[S-1:H]);
      m1_q_hl_ff <= (H+L)'(da[S-1:H]) * (H+L)'(db[H-1:0]);
      m1_q_hh_ff <= (2*L)'(da[S-1:H]) * (2*L)'(db[S-1:H]);
      m1_den_ff  <= job_den;
      m1_zero_ff <= job_zero;
   end

   always_comb begin
      m2_p_in = (QW'(m1_p_hh_ff) << (2*H))
              + ((QW'(m1_p_lh_ff) + QW'(m1_p_hl_ff)) << H)
              + QW'(m1_p_ll_ff);
      m2_q_in = (QW'(m1_q_hh_ff) << (2*H))
              + ((QW'(m1_q_lh_ff) + QW'(m1_q_hl_ff)) << H)
              + QW'(m1_q_ll_ff);
   end

   always_ff @(posedge clock) begin
      m2_p_ff    <= m2_p_in;
      m2_q_ff    <= m2_q_in;
      m2_den_ff  <= m1_den_ff;
      m2_zero_ff <= m1_zero_ff;
   end

   always_comb begin
      neg_in = (m2_p_ff < m2_q_ff);
      mag_in = neg_in ? (m2_q_ff - m2_p_ff) : (m2_p_ff - m2_q_ff);
   end

   always_ff @(posedge clock) begin
      div_quo_ff[0]  <= mag_in;
      div_rem_ff[0]  <= '0;
      div_den_ff[0]  <= m2_den_ff;
      div_neg_ff[0]  <= neg_in;
      div_zero_ff[0] <= m2_zero_ff;
   end

   assign div_quo_in[0] = '0;
   assign div_rem_in[0] = '0;

   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [DW:0] trial;
      logic        ge;

      assign trial         = {div_rem_ff[k-1], div_quo_ff[k-1][QW-1]};
      assign ge            = (trial >= {1'b0, div_den_ff[k-1]});
      assign div_rem_in[k] = ge ? DW'(trial - {1'b0, div_den_ff[k-1]}) : DW'(trial);
      assign div_quo_in[k] = {div_quo_ff[k-1][QW-2:0], ge};

      always_ff @(posedge clock) begin
         div_quo_ff[k]  <= div_quo_in[k];
         div_rem_ff[k]  <= div_rem_in[k];
         div_den_ff[k]  <= div_den_ff[k-1];
         div_neg_ff[k]  <= div_neg_ff[k-1];
         div_zero_ff[k] <= div_zero_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k] <= 1'b0;
         end else begin
            div_vld_ff[k] <= div_vld_ff[k-1];
         end
      end
   end

   always_comb begin
      quo_ext = EW'(div_quo_ff[QW]);
      if (div_neg_ff[QW]) begin
         mag33 = (quo_ext > NEG_LIM) ? NEG_LIM[32:0] : quo_ext[32:0];
         out_data_in.flight_time = $signed(~mag33 + 33'd1);
      end else begin
         mag33 = (quo_ext > POS_LIM) ? POS_LIM[32:0] : quo_ext[32:0];
         out_data_in.flight_time = $signed(mag33);
      end
      out_data_in.zero_divisor = div_zero_ff[QW];
      if (div_zero_ff[QW]) begin
         out_data_in.flight_time = '0;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff     <= 1'b0;
         m2_vld_ff     <= 1'b0;
         div_vld_ff[0] <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         m1_vld_ff     <= pop;
         m2_vld_ff     <= m1_vld_ff;
         div_vld_ff[0] <= m2_vld_ff;
         out_vld_ff    <= div_vld_ff[QW];
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hdl/ds_twr_time_of_flight_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight_top
// Asymmetric double-sided two-way ranging: time of flight from six stamps.
// ----------------------------------------------------------------------------
// Drive req_data and raise start; the item is taken at the rising edge where
// start is high and busy is low. Each item gives one result, shown on
// rsp_data for exactly one cycle with rsp_valid high. The receiver cannot
// hold results off and every result must be captured when strobed.
// Each result passes through the front register, the queue, two product
// stages, the numerator register, the one-bit-per-stage divider of
// 2*STAMP_BITS stages and the output register before rsp_valid rises.
// Throughput: one item per cycle; busy stays low in normal use and rises
// only if the queue between front and back end fills.
// Reset clears the front, queue and all pipeline valid bits; items in
// flight are dropped and no result follows them.
// A zero interval sum gives zero_divisor high and flight_time zero.
// ----------------------------------------------------------------------------
module ds_twr_time_of_flight_top #(
   parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  dstwr_pkg::req_item_type  req_data,
   output logic                     rsp_valid,
   output dstwr_pkg::rsp_item_type  rsp_data
);
   import dstwr_pkg::*;

   localparam int JW = 5*STAMP_BITS + 3;

   queue_status_type q_status;
   logic             push, pop;
   logic [JW-1:0]    push_job, pop_job;

   dstwr_front #(.STAMP_BITS(STAMP_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_status (q_status),
      .push     (push),
      .job      (push_job)
   );

   dstwr_queue #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .status    (q_status)
   );

   dstwr_back #(.STAMP_BITS(STAMP_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop       (pop),
      .job       (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/dstwr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstwr_checker
// Port-level checks on the time-of-flight block, bound to the top level.
// ----------------------------------------------------------------------------
module dstwr_checker #(
   parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic                     rsp_valid,
   input  dstwr_pkg::rsp_item_type  rsp_data
);
   import dstwr_pkg::*;

   localparam int LAT = 2*STAMP_BITS + 6;

   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_item_gives_result : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted item gave no result at fixed latency");

   a_result_has_item : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without accepted item");

   a_zero_divisor : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_divisor) |-> (rsp_data.flight_time == '0))
      else $error("zero divisor with nonzero flight time");

endmodule

bind ds_twr_time_of_flight_top dstwr_checker #(.STAMP_BITS(STAMP_BITS)) u_dstwr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
